>>> src/cdq_pkg.sv
// Shared types and constants for the circular deque.
`default_nettype none

package cdq_pkg;

	localparam int DATA_W = 32;
	localparam int CFG_W  = 11;
	localparam int CAP_RESET = 1024;

	localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} stat_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_READ = 1'b1
	} fsm_t;

	// per-beat outcome from the pointer unit
	typedef struct packed {
		stat_t status;
		logic  empty;      // empty after the operation
		logic  full;       // full after the operation
		logic  need_read;  // new end value must come from the ring
		logic  read_front; // the read refills the front value
		logic  set_both;   // push into empty deque
		logic  set_front;
		logic  set_back;
	} step_t;

endpackage

`default_nettype wire

>>> src/cdq_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

>>> src/cdq_ptr.sv
// Front/back index, fill count and capacity bookkeeping for the deque.
`default_nettype none

module cdq_ptr #(
	parameter int DEPTH = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [cdq_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                         step_en,
	input  wire cdq_pkg::op_t                 op,
	output cdq_pkg::step_t                    step,
	output logic                              ram_we,
	output logic                              ram_re,
	output logic      [$clog2(DEPTH)-1:0]     ram_addr
);

	localparam int IW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int WW    = (CNT_W > cdq_pkg::CFG_W) ? CNT_W : cdq_pkg::CFG_W;
	localparam int CAP_RST = (DEPTH < cdq_pkg::CAP_RESET) ? DEPTH : cdq_pkg::CAP_RESET;

	logic [IW-1:0]    front_q, back_q, capm1_q;
	logic [CNT_W-1:0] cnt_q, cap_q;
	logic [IW-1:0]    front_d, back_d;
	logic [CNT_W-1:0] cnt_d;
	logic [WW-1:0]    cfg_ext;
	logic [CNT_W-1:0] cap_new;
	logic             is_empty, is_full;

	// clamp the written capacity into 1..DEPTH
	always_comb begin
		cfg_ext = WW'(cfg_data);
		if (cfg_ext == '0) begin
			cap_new = CNT_W'(1);
		end else if (cfg_ext > WW'(DEPTH)) begin
			cap_new = CNT_W'(DEPTH);
		end else begin
			cap_new = CNT_W'(cfg_ext);
		end
	end

	assign is_empty = (cnt_q == '0);
	assign is_full  = (cnt_q >= cap_q);

	always_comb begin
		front_d  = front_q;
		back_d   = back_q;
		cnt_d    = cnt_q;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = '0;
		step     = '0;
		step.status = cdq_pkg::ST_DONE;
		unique case (op) inside
			cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_BACK: begin
				if (is_full) begin
					step.status = cdq_pkg::ST_OVERFLOW;
				end else if (is_empty) begin
					front_d       = '0;
					back_d        = '0;
					cnt_d         = CNT_W'(1);
					ram_we        = 1'b1;
					step.set_both = 1'b1;
				end else if (op == cdq_pkg::OP_PUSH_FRONT) begin
					front_d        = (front_q == '0) ? capm1_q : front_q - IW'(1);
					cnt_d          = cnt_q + CNT_W'(1);
					ram_we         = 1'b1;
					ram_addr       = front_d;
					step.set_front = 1'b1;
				end else begin
					back_d        = (back_q >= capm1_q) ? '0 : back_q + IW'(1);
					cnt_d         = cnt_q + CNT_W'(1);
					ram_we        = 1'b1;
					ram_addr      = back_d;
					step.set_back = 1'b1;
				end
			end
			cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK: begin
				if (is_empty) begin
					step.status = cdq_pkg::ST_UNDERFLOW;
				end else if (cnt_q == CNT_W'(1)) begin
					front_d = '0;
					back_d  = '0;
					cnt_d   = '0;
				end else if (op == cdq_pkg::OP_POP_FRONT) begin
					front_d         = (front_q >= capm1_q) ? '0 : front_q + IW'(1);
					cnt_d           = cnt_q - CNT_W'(1);
					ram_re          = 1'b1;
					ram_addr        = front_d;
					step.need_read  = 1'b1;
					step.read_front = 1'b1;
				end else begin
					back_d         = (back_q == '0) ? capm1_q : back_q - IW'(1);
					cnt_d          = cnt_q - CNT_W'(1);
					ram_re         = 1'b1;
					ram_addr       = back_d;
					step.need_read = 1'b1;
				end
			end
			default: begin
				step.status = cdq_pkg::ST_DONE;
			end
		endcase
		step.empty = (cnt_d == '0);
		step.full  = (cnt_d == cap_q);
		ram_we = ram_we & step_en;
		ram_re = ram_re & step_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			cnt_q   <= '0;
			cap_q   <= CNT_W'(CAP_RST);
			capm1_q <= IW'(CAP_RST - 1);
		end else if (cfg_we) begin
			front_q <= '0;
			back_q  <= '0;
			cnt_q   <= '0;
			cap_q   <= cap_new;
			capm1_q <= IW'(cap_new - CNT_W'(1));
		end else if (step_en) begin
			front_q <= front_d;
			back_q  <= back_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

>>> src/circular_deque.sv
// Top level of the circular deque: handshakes, end-value cache, result register.
//
// Channel   Dir  Handshake                     Payload
// cfg       in   cfg_valid / cfg_ready         cfg_data: capacity_in_use (11 b)
// s_axis    in   s_axis_tvalid / tready        tuser: operation, tdata: push_value
// m_axis    out  m_axis_tvalid / tready        tuser: status, tdata: front, back, flags
//
// Pushes, refused operations and pops of the last element load the result
// register directly. A pop that leaves elements behind passes through READ:
// the new end value is read from the ring RAM, whose read data is registered.
// Beats are taken in IDLE only, while out_free is set and cfg_valid is low.
// Reset empties the deque and sets capacity to 1024 (or DEPTH, if smaller); the
// ring contents are not cleared. A capacity write empties the deque as well.
`default_nettype none

module circular_deque #(
	parameter int DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// capacity register write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [10:0] cfg_data,       // [10:0] capacity_in_use
	// operation beats
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] push_value
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation
	// result beats
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [71:0] m_axis_tdata,   // [31:0] front_value, [63:32] back_value,
	                                         // [64] is_empty, [65] is_full, [71:66] zero
	output logic      [1:0]  m_axis_tuser    // [1:0] status
);

	localparam int IW = $clog2(DEPTH);

	cdq_pkg::fsm_t  fsm_q, fsm_d;
	cdq_pkg::step_t step;
	logic           accept, cfg_we, load_idle, load_read, out_free;
	logic           ram_we, ram_re;
	logic [IW-1:0]  ram_addr;
	logic [31:0]    ram_rdata;

	// cached end values; only meaningful while the deque is non-empty
	logic [31:0] front_val_q, back_val_q;
	logic [31:0] front_nxt, back_nxt;

	// context held across the RAM read
	logic        full_s1;
	logic        rdfront_s1;

	// result register
	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [31:0] out_front_q, out_back_q;
	logic        out_empty_q, out_full_q;

	assign out_free = !out_valid_q || m_axis_tready;
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign cfg_we   = cfg_valid && cfg_ready;

	cdq_ptr #(
		.DEPTH (DEPTH)
	) u_ptr (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.step_en  (accept),
		.op       (cdq_pkg::op_t'(s_axis_tuser)),
		.step     (step),
		.ram_we   (ram_we),
		.ram_re   (ram_re),
		.ram_addr (ram_addr)
	);

	cdq_ram #(
		.WIDTH (cdq_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (s_axis_tdata),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		fsm_d = fsm_q;
		unique case (fsm_q)
			cdq_pkg::FSM_IDLE: begin
				if (accept && step.need_read) begin
					fsm_d = cdq_pkg::FSM_READ;
				end
			end
			cdq_pkg::FSM_READ: begin
				fsm_d = cdq_pkg::FSM_IDLE;
			end
			default: begin
				fsm_d = cdq_pkg::FSM_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = 1'b0;
		cfg_ready     = 1'b0;
		load_idle     = 1'b0;
		load_read     = 1'b0;
		unique case (fsm_q)
			cdq_pkg::FSM_IDLE: begin
				cfg_ready     = 1'b1;
				// config wins over a beat offered in the same cycle
				s_axis_tready = out_free && !cfg_valid;
				load_idle     = accept && !step.need_read;
			end
			cdq_pkg::FSM_READ: begin
				load_read = 1'b1;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	// end values after a push (pops only keep or refill them)
	always_comb begin
		front_nxt = front_val_q;
		back_nxt  = back_val_q;
		if (step.set_both) begin
			front_nxt = s_axis_tdata;
			back_nxt  = s_axis_tdata;
		end
		if (step.set_front) begin
			front_nxt = s_axis_tdata;
		end
		if (step.set_back) begin
			back_nxt = s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= cdq_pkg::FSM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			fsm_q <= fsm_d;
			if (load_idle || load_read) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: cache, read context and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			front_val_q <= front_nxt;
			back_val_q  <= back_nxt;
			full_s1     <= step.full;
			rdfront_s1  <= step.read_front;
		end
		if (load_idle) begin
			out_status_q <= step.status;
			out_empty_q  <= step.empty;
			out_full_q   <= step.full;
			out_front_q  <= step.empty ? cdq_pkg::EMPTY_VALUE : front_nxt;
			out_back_q   <= step.empty ? cdq_pkg::EMPTY_VALUE : back_nxt;
		end
		if (load_read) begin
			// a refilling pop always succeeds and leaves the deque non-empty
			out_status_q <= cdq_pkg::ST_DONE;
			out_empty_q  <= 1'b0;
			out_full_q   <= full_s1;
			if (rdfront_s1) begin
				front_val_q <= ram_rdata;
				out_front_q <= ram_rdata;
				out_back_q  <= back_val_q;
			end else begin
				back_val_q  <= ram_rdata;
				out_front_q <= front_val_q;
				out_back_q  <= ram_rdata;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {6'b0, out_full_q, out_empty_q, out_back_q, out_front_q};

`ifndef SYNTHESIS
	// the result register is free while a refill read is in flight
	a_read_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == cdq_pkg::FSM_READ |-> !m_axis_tvalid)
		else $error("result pending during ring read");

	// every accepted beat loads the result register or starts the refill read
	a_beat_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid || fsm_q == cdq_pkg::FSM_READ)
		else $error("accepted beat produced no result");

	// an empty result shows the empty marker on both ends and is never full
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[64] |->
			m_axis_tdata[31:0] == cdq_pkg::EMPTY_VALUE &&
			m_axis_tdata[63:32] == cdq_pkg::EMPTY_VALUE && !m_axis_tdata[65])
		else $error("empty result with bad end values or full flag");

	// a refused pop (underflow) leaves the deque empty
	a_refused_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == cdq_pkg::ST_UNDERFLOW |-> m_axis_tdata[64])
		else $error("underflow reported on a non-empty deque");
`endif

endmodule

`default_nettype wire

>>> verif/circular_deque_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for circular_deque: directed and random beats against a predictor.
module circular_deque_test;

	localparam int RING_DEPTH  = 1024;
	localparam int RING_IW     = $clog2(RING_DEPTH);
	localparam int CLK_HALF    = 10;
	localparam int TAIL_CYCLES = 4;       // covers the refill read and the result register
	localparam int CYCLE_LIMIT = 400000;  // watchdog that ends a hung run with FAIL
	localparam int PRINT_LIMIT = 40;
	localparam int MODE_SPAN   = 40;      // beats per idle mode before rotating

	// idle modes: sender/receiver gap percentages
	localparam int MODE_NONE   = 0;
	localparam int MODE_SENDER = 1;
	localparam int MODE_RECVR  = 2;
	localparam int MODE_BOTH   = 3;

	typedef struct packed {
		cdq_pkg::stat_t             status;
		logic [cdq_pkg::DATA_W-1:0] front;
		logic [cdq_pkg::DATA_W-1:0] back;
		logic                       empty;
		logic                       full;
	} deque_result_t;

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      cfg_valid     = 1'b0;
	logic                      cfg_ready;
	logic [cdq_pkg::CFG_W-1:0] cfg_data      = '0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [31:0]               s_axis_tdata  = '0;   // [31:0] push_value
	logic [1:0]                s_axis_tuser  = '0;   // [1:0] operation
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [71:0]               m_axis_tdata;   // [31:0] front, [63:32] back, [64] empty, [65] full
	logic [1:0]                m_axis_tuser;   // [1:0] status

	circular_deque #(
		.DEPTH(RING_DEPTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// predictor copy of the deque
	logic [cdq_pkg::DATA_W-1:0] ring_copy [RING_DEPTH];
	int unsigned                head_slot;
	int unsigned                tail_slot;
	bit                         deque_empty;
	logic [cdq_pkg::CFG_W-1:0]  capacity_reg;

	deque_result_t     pending_results [$];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int          idle_mode      = MODE_NONE;
	int          mismatch_count = 0;
	int unsigned cycle_count    = 0;

	initial forever #CLK_HALF clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// register value 0 acts as 1, anything above the ring depth acts as the depth
	function automatic int unsigned usable_slots();
		int unsigned c;
		c = 32'(capacity_reg);
		if (c == 0) c = 1;
		if (c > RING_DEPTH) c = RING_DEPTH;
		return c;
	endfunction

	function automatic int unsigned held_elements(int unsigned cap);
		if (deque_empty) return 0;
		if (tail_slot >= head_slot) return tail_slot - head_slot + 1;
		return tail_slot + cap - head_slot + 1;
	endfunction

	function automatic void clear_deque();
		head_slot   = 0;
		tail_slot   = 0;
		deque_empty = 1'b1;
	endfunction

	// updates the copy for one accepted beat and returns the result it must produce
	function automatic deque_result_t apply_op(cdq_pkg::op_t op,
			logic [cdq_pkg::DATA_W-1:0] value);
		deque_result_t r;
		int unsigned   cap;
		cap      = usable_slots();
		r.status = cdq_pkg::ST_DONE;
		case (op) inside
		cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_BACK: begin
			if (held_elements(cap) >= cap) begin
				r.status = cdq_pkg::ST_OVERFLOW;
			end else if (deque_empty) begin
				// first element always lands in slot 0
				head_slot   = 0;
				tail_slot   = 0;
				deque_empty = 1'b0;
				ring_copy[RING_IW'(0)] = value;
			end else if (op == cdq_pkg::OP_PUSH_FRONT) begin
				head_slot = (head_slot == 0) ? cap - 1 : head_slot - 1;
				ring_copy[RING_IW'(head_slot)] = value;
			end else begin
				tail_slot = (tail_slot >= cap - 1) ? 0 : tail_slot + 1;
				ring_copy[RING_IW'(tail_slot)] = value;
			end
		end
		default: begin
			if (deque_empty) begin
				r.status = cdq_pkg::ST_UNDERFLOW;
			end else if (head_slot == tail_slot) begin
				clear_deque();   // last element gone, indices back to 0
			end else if (op == cdq_pkg::OP_POP_FRONT) begin
				head_slot = (head_slot >= cap - 1) ? 0 : head_slot + 1;
			end else begin
				tail_slot = (tail_slot == 0) ? cap - 1 : tail_slot - 1;
			end
		end
		endcase
		r.front = deque_empty ? cdq_pkg::EMPTY_VALUE : ring_copy[RING_IW'(head_slot)];
		r.back  = deque_empty ? cdq_pkg::EMPTY_VALUE : ring_copy[RING_IW'(tail_slot)];
		r.empty = deque_empty;
		r.full  = (held_elements(cap) == cap);
		return r;
	endfunction

	// ---------------------------------------------------------------- drivers

	always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic set_idle_mode(input int mode);
		case (mode)
		MODE_SENDER: begin send_idle_pct = 68; recv_stall_pct = 0;  end
		MODE_RECVR:  begin send_idle_pct = 0;  recv_stall_pct = 68; end
		MODE_BOTH:   begin send_idle_pct = 6;  recv_stall_pct = 6;  end
		default:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
		endcase
	endtask

	task automatic rotate_idle_mode();
		idle_mode = (idle_mode + 1) % 4;
		set_idle_mode(idle_mode);
	endtask

	// one operation beat; returns in the time step of the handshake with tvalid still high
	task automatic send_op(input cdq_pkg::op_t op, input logic [cdq_pkg::DATA_W-1:0] value);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= value;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(apply_op(op, value));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// capacity writes only go out with the deque idle
	task automatic write_capacity(input logic [cdq_pkg::CFG_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		capacity_reg = value;
		clear_deque();
	endtask

	function automatic logic [cdq_pkg::DATA_W-1:0] random_value();
		case ($urandom_range(15))
		0:       return 32'h8000_0000;
		1:       return 32'h7FFF_FFFF;
		2:       return '0;
		3:       return '1;
		default: return $urandom;
		endcase
	endfunction

	function automatic cdq_pkg::op_t random_op(input int unsigned push_pct);
		if ($urandom_range(99) < push_pct)
			return $urandom_range(1) ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_BACK;
		return $urandom_range(1) ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_BACK;
	endfunction

	// random walk: alternating fill and drain bias so small rings hit both full and empty
	task automatic run_mix(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % MODE_SPAN == 0) rotate_idle_mode();
			send_op(random_op(((i / 10) % 2) ? 25 : 75), random_value());
		end
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input logic [71:0] got,
			input logic [71:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_result();
		deque_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("unexpected result beat", m_axis_tdata, '0);
		end else begin
			want = pending_results.pop_front();
			if (m_axis_tuser !== want.status)
				report_mismatch("status", 72'(m_axis_tuser), 72'(want.status));
			if (m_axis_tdata[31:0] !== want.front)
				report_mismatch("front_value", 72'(m_axis_tdata[31:0]), 72'(want.front));
			if (m_axis_tdata[63:32] !== want.back)
				report_mismatch("back_value", 72'(m_axis_tdata[63:32]), 72'(want.back));
			if (m_axis_tdata[64] !== want.empty)
				report_mismatch("is_empty", 72'(m_axis_tdata[64]), 72'(want.empty));
			if (m_axis_tdata[65] !== want.full)
				report_mismatch("is_full", 72'(m_axis_tdata[65]), 72'(want.full));
			if (m_axis_tdata[71:66] !== '0)
				report_mismatch("tdata padding", 72'(m_axis_tdata[71:66]), '0);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) check_result();
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- tests

	// reset capacity, underflow on both ends, extreme values, pop of the last element
	task automatic test_reset_state();
		set_idle_mode(MODE_NONE);
		send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
		send_op(cdq_pkg::OP_POP_BACK, 32'hFFFF_FFFF);
		send_op(cdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
		send_op(cdq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
		send_op(cdq_pkg::OP_PUSH_FRONT, 32'h0);
		send_op(cdq_pkg::OP_POP_FRONT, 32'h5555_5555);
		send_op(cdq_pkg::OP_POP_BACK, 32'hAAAA_AAAA);
		send_op(cdq_pkg::OP_POP_BACK, 32'h0);
	endtask

	// capacity 0 behaves as 1: full after one push, overflow on both ends
	task automatic test_single_slot();
		write_capacity(11'd0);
		set_idle_mode(MODE_NONE);
		send_op(cdq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
		send_op(cdq_pkg::OP_PUSH_FRONT, 32'h1234_5678);
		send_op(cdq_pkg::OP_PUSH_BACK, 32'h8765_4321);
		send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
		send_op(cdq_pkg::OP_POP_BACK, 32'h0);
		write_capacity(11'd1);
		send_op(cdq_pkg::OP_PUSH_FRONT, 32'h0000_0001);
		send_op(cdq_pkg::OP_POP_BACK, 32'h0);
	endtask

	// front index wrapping below slot 0, back index wrapping past the top
	task automatic test_wraparound();
		write_capacity(11'd3);
		set_idle_mode(MODE_NONE);
		send_op(cdq_pkg::OP_PUSH_BACK, 32'hA5A5_A5A5);
		send_op(cdq_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A);
		send_op(cdq_pkg::OP_PUSH_FRONT, 32'h0000_0001);
		send_op(cdq_pkg::OP_PUSH_BACK, 32'h0000_0002);
		send_op(cdq_pkg::OP_POP_BACK, 32'h0);
		send_op(cdq_pkg::OP_PUSH_BACK, 32'h0000_0003);
		send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
		send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
		send_op(cdq_pkg::OP_POP_FRONT, 32'h0);
	endtask

	task automatic test_random_capacities();
		logic [cdq_pkg::CFG_W-1:0] caps [7];
		caps = '{11'd2, 11'd5, 11'd8, 11'd16, 11'd1,
			cdq_pkg::CFG_W'($urandom_range(64, 1)), cdq_pkg::CFG_W'($urandom_range(40, 0))};
		foreach (caps[k]) begin
			write_capacity(caps[k]);
			run_mix(40);
		end
	endtask

	// 1025 clamps to the ring depth: fill the whole ring, overflow, then mix
	task automatic test_full_ring();
		int n;
		write_capacity(11'd1025);
		n = 0;
		while (held_elements(usable_slots()) < usable_slots()) begin
			if (n % MODE_SPAN == 0) rotate_idle_mode();
			send_op(random_op(100), random_value());
			n++;
		end
		send_op(cdq_pkg::OP_PUSH_FRONT, random_value());
		send_op(cdq_pkg::OP_PUSH_BACK, random_value());
		run_mix(60);
		write_capacity(11'd2047);
		run_mix(20);
	endtask

	initial begin
		capacity_reg = cdq_pkg::CFG_W'(cdq_pkg::CAP_RESET);
		clear_deque();
		set_idle_mode(MODE_NONE);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_single_slot();
		test_wraparound();
		test_random_capacities();
		test_full_ring();

		wait_drained();
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
